### rtl/dcrl_pkg.sv
// ----------------------------------------------------------------------------
// dcrl_pkg: shared types and constants for the dual-copy record loader
// Record layout, default values, status codes and the structs that pass
// between the lane checkers, the merge stage and the top level.
// ----------------------------------------------------------------------------
package dcrl_pkg;

    localparam int RECORD_BYTES = 8;
    localparam int RECORD_W     = 8 * RECORD_BYTES;
    localparam int ADDR_W       = 40;

    localparam logic [ADDR_W-1:0] DEFAULT_ADDRESS = 40'h01_0000_0001;
    localparam logic [7:0]        DEFAULT_CHANNEL = 8'h40;
    localparam logic [7:0]        GROUP_FLAG      = 8'h80;

    // Byte positions inside a record.
    localparam int CHANNEL_BYTE = 5;
    localparam int GROUP_BYTE   = 6;
    localparam int TYPE_BYTE    = 7;

    typedef enum logic [1:0] {
        PAIR_UNPAIRED = 2'd0,
        PAIR_MODE     = 2'd1,
        PAIR_RECORD   = 2'd2
    } pair_status_t;

    // Verdict of one lane on one copy.
    typedef struct packed {
        logic group_ok;   // bytes 0..6 all valid
        logic all_ok;     // bytes 0..7 all valid
    } lane_verdict_t;

    typedef struct packed {
        logic [ADDR_W-1:0] link_address;
        logic [7:0]        channel;
        logic [7:0]        group;
        logic [7:0]        device_type;
        pair_status_t      pair_status;
        logic              from_backup;
    } load_result_t;

endpackage

### rtl/dcrl_lane.sv
// ----------------------------------------------------------------------------
// dcrl_lane: integrity check of one record copy
// Compares every byte with the inverse of its check byte in parallel and
// reports how far the valid prefix reaches.
// ----------------------------------------------------------------------------
module dcrl_lane (
    input  logic [dcrl_pkg::RECORD_W-1:0] copy_data,
    input  logic [dcrl_pkg::RECORD_W-1:0] check_data,
    output dcrl_pkg::lane_verdict_t       verdict
);

    logic [dcrl_pkg::RECORD_BYTES-1:0] byte_ok;

    always_comb begin
        for (int k = 0; k < dcrl_pkg::RECORD_BYTES; k++) begin
            byte_ok[k] = (copy_data[8*k +: 8] == ~check_data[8*k +: 8]);
        end
    end

    assign verdict.group_ok = &byte_ok[dcrl_pkg::GROUP_BYTE:0];
    assign verdict.all_ok   = &byte_ok;

endmodule

### rtl/dcrl_merge.sv
// ----------------------------------------------------------------------------
// dcrl_merge: combines the two lane verdicts into one load result
// Picks the copy to load, updates the group and type holds and builds the
// address, channel and status.
// ----------------------------------------------------------------------------
module dcrl_merge (
    input  logic [dcrl_pkg::RECORD_W-1:0] primary_copy,
    input  logic [dcrl_pkg::RECORD_W-1:0] backup_copy,
    input  dcrl_pkg::lane_verdict_t       primary_verdict,
    input  dcrl_pkg::lane_verdict_t       backup_verdict,
    input  logic                          pairing,
    input  logic [7:0]                    group_hold,
    input  logic [7:0]                    type_hold,
    output dcrl_pkg::load_result_t        result
);

    logic [dcrl_pkg::RECORD_W-1:0] chosen;
    logic [7:0]                    group_new;
    logic [7:0]                    type_new;

    always_comb begin
        group_new = group_hold;
        type_new  = type_hold;
        chosen    = primary_verdict.all_ok ? primary_copy : backup_copy;

        result.link_address = dcrl_pkg::DEFAULT_ADDRESS;
        result.channel      = dcrl_pkg::DEFAULT_CHANNEL;
        result.pair_status  = dcrl_pkg::PAIR_MODE;
        result.from_backup  = 1'b0;

        if (!pairing) begin
            // The primary's valid prefix is written first; the backup is
            // only walked when the primary fails, so it writes last.
            if (primary_verdict.group_ok) begin
                group_new = primary_copy[8*dcrl_pkg::GROUP_BYTE +: 8];
            end
            if (primary_verdict.all_ok) begin
                type_new = primary_copy[8*dcrl_pkg::TYPE_BYTE +: 8];
            end
            if (!primary_verdict.all_ok) begin
                if (backup_verdict.group_ok) begin
                    group_new = backup_copy[8*dcrl_pkg::GROUP_BYTE +: 8];
                end
                if (backup_verdict.all_ok) begin
                    type_new = backup_copy[8*dcrl_pkg::TYPE_BYTE +: 8];
                end
            end

            if (primary_verdict.all_ok || backup_verdict.all_ok) begin
                result.link_address    = chosen[dcrl_pkg::ADDR_W-1:0];
                result.link_address[7] = (group_new == dcrl_pkg::GROUP_FLAG);
                result.channel         = chosen[8*dcrl_pkg::CHANNEL_BYTE +: 8];
                result.pair_status     = dcrl_pkg::PAIR_RECORD;
                result.from_backup     = !primary_verdict.all_ok;
            end else begin
                result.pair_status     = dcrl_pkg::PAIR_UNPAIRED;
            end
        end

        result.group       = group_new;
        result.device_type = type_new;
    end

endmodule

### rtl/dual_copy_record_loader.sv
// ----------------------------------------------------------------------------
// dual_copy_record_loader: loads a pairing record from two guarded copies
// Two parallel lanes check the primary and backup copies against their
// complement images; a merge stage selects the copy, keeps the group and
// type holds and produces the address, channel and pairing status.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Payload
//  --------+-----------+------------------------------------------------------
//  s_      | in        | tdata: four 64-bit record images, tuser: pairing
//  m_      | out       | tdata: address, channel, group, type;
//          |           | tuser: pair status, backup flag
//
// Every beat is fully evaluated in the cycle it is accepted: the two lane
// comparators and the merge stage are purely combinational, so one record
// is taken per cycle unless stalled and its result appears on the output
// register on the next cycle. The group and type holds are updated in that
// same cycle, so a following beat sees them at once. Reset (aresetn low,
// synchronous) clears the holds and empties the output register. The input is
// stalled only while the output register is full and the sink is not ready.
// ----------------------------------------------------------------------------
module dual_copy_record_loader (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_tvalid,
    output logic         s_tready,
    // [63:0] primary_copy, [127:64] primary_check,
    // [191:128] backup_copy, [255:192] backup_check
    input  logic [255:0] s_tdata,
    // [0] pairing
    input  logic         s_tuser,

    output logic         m_tvalid,
    input  logic         m_tready,
    // [39:0] link_address, [47:40] channel, [55:48] group, [63:56] device_type
    output logic [63:0]  m_tdata,
    // [1:0] pair_status, [2] from_backup
    output logic [2:0]   m_tuser
);

    logic                   accept;
    dcrl_pkg::lane_verdict_t primary_verdict;
    dcrl_pkg::lane_verdict_t backup_verdict;
    dcrl_pkg::load_result_t  result;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    dcrl_pkg::load_result_t  out_data_reg;
    logic [7:0]             group_hold_reg;
    logic [7:0]             group_hold_next;
    logic [7:0]             type_hold_reg;
    logic [7:0]             type_hold_next;

    // The output register may be refilled in the cycle it is drained.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // One lane per stored copy.
    dcrl_lane u_lane_primary (
        .copy_data  (s_tdata[0 +: dcrl_pkg::RECORD_W]),
        .check_data (s_tdata[dcrl_pkg::RECORD_W +: dcrl_pkg::RECORD_W]),
        .verdict    (primary_verdict)
    );

    dcrl_lane u_lane_backup (
        .copy_data  (s_tdata[2*dcrl_pkg::RECORD_W +: dcrl_pkg::RECORD_W]),
        .check_data (s_tdata[3*dcrl_pkg::RECORD_W +: dcrl_pkg::RECORD_W]),
        .verdict    (backup_verdict)
    );

    dcrl_merge u_merge (
        .primary_copy    (s_tdata[0 +: dcrl_pkg::RECORD_W]),
        .backup_copy     (s_tdata[2*dcrl_pkg::RECORD_W +: dcrl_pkg::RECORD_W]),
        .primary_verdict (primary_verdict),
        .backup_verdict  (backup_verdict),
        .pairing         (s_tuser),
        .group_hold      (group_hold_reg),
        .type_hold       (type_hold_reg),
        .result          (result)
    );

    always_comb begin
        out_valid_next  = out_valid_reg && !m_tready;
        group_hold_next = group_hold_reg;
        type_hold_next  = type_hold_reg;
        if (accept) begin
            out_valid_next  = 1'b1;
            group_hold_next = result.group;
            type_hold_next  = result.device_type;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            group_hold_reg <= 8'h00;
            type_hold_reg  <= 8'h00;
        end else begin
            out_valid_reg  <= out_valid_next;
            group_hold_reg <= group_hold_next;
            type_hold_reg  <= type_hold_next;
        end
    end

    // Payload register: loaded on every accepted beat, no reset needed.
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg.device_type, out_data_reg.group,
                       out_data_reg.channel, out_data_reg.link_address};
    assign m_tuser  = {out_data_reg.from_backup, out_data_reg.pair_status};

endmodule
